@@ hdl/wtes_pkg.sv @@
// ----------------------------------------------------------------------------
// Weighted tardiness search package
// Shared sizes, constants and transfer types for the exhaustive search core.
// ----------------------------------------------------------------------------
package wtes_pkg;

  // Largest batch of jobs that one search handles.
  localparam int MAX_TASKS = 8;

  // Width of a job slot index and of a count that can hold MAX_TASKS itself.
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  localparam int ID_W    = 8;
  localparam int PTIME_W = 16;
  localparam int WT_W    = 8;
  localparam int DUE_W   = 20;
  localparam int COST_W  = 31;

  // Completion time never exceeds MAX_TASKS * (2**PTIME_W - 1).
  localparam int TIME_W  = $clog2(MAX_TASKS * ((1 << PTIME_W) - 1) + 1) > DUE_W ?
                           $clog2(MAX_TASKS * ((1 << PTIME_W) - 1) + 1) : DUE_W;
  localparam int PROD_W  = TIME_W + WT_W;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PTIME_W-1:0] ptime;
    logic [WT_W-1:0]    wt;
    logic [DUE_W-1:0]   due;
  } job_t;

  typedef struct packed {
    logic [ID_W-1:0]    job_id;
    logic [PTIME_W-1:0] proc_time;
    logic [WT_W-1:0]    weight;
    logic [DUE_W-1:0]   due_date;
    logic               last_job;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   order_id;
    logic [COST_W-1:0] best_cost;
    logic              last_result;
  } out_item_t;

  // Write into the job store.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    job_t             data;
  } mem_wr_t;

  // Read from the job store; eval marks reads that feed the cost pipeline.
  typedef struct packed {
    logic             en;
    logic             eval;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  // Result hand-off from the sequencer to the output register.
  typedef struct packed {
    logic              vld;
    logic              last;
    logic [COST_W-1:0] cost;
  } emit_t;

endpackage

@@ hdl/wtes_cost_unit.sv @@
// ----------------------------------------------------------------------------
// Weighted tardiness cost unit
// Job store plus a pipelined accumulate of weight times tardiness.
// ----------------------------------------------------------------------------
module wtes_cost_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wtes_pkg::mem_wr_t           wr,
  input  wtes_pkg::rd_req_t           rd,
  output wtes_pkg::job_t              rd_data,
  output logic                        cost_vld,
  output logic [wtes_pkg::COST_W-1:0] cost
);

  wtes_pkg::job_t mem_r [wtes_pkg::MAX_TASKS];
  wtes_pkg::job_t rd_data_r;

  logic v1_r, first1_r, last1_r;
  logic v2_r, first2_r, last2_r;
  logic v3_r, first3_r, last3_r;
  logic v4_r, first4_r, last4_r;
  logic cost_vld_r;

  logic [wtes_pkg::TIME_W-1:0] t_r;
  logic [wtes_pkg::DUE_W-1:0]  due2_r;
  logic [wtes_pkg::WT_W-1:0]   wt2_r, wt3_r;
  logic [wtes_pkg::TIME_W-1:0] tard_r;
  logic [wtes_pkg::PROD_W-1:0] prod_r;
  logic [wtes_pkg::COST_W-1:0] sum_r;

  logic [wtes_pkg::TIME_W-1:0] t_base;
  logic [wtes_pkg::TIME_W-1:0] due_ext;
  logic [wtes_pkg::COST_W:0]   sum_raw;
  logic [wtes_pkg::COST_W-1:0] sum_base;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem_r[rd.addr];
    end
  end

  // Pipeline control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      cost_vld_r <= 1'b0;
      first1_r   <= 1'b0;
      first2_r   <= 1'b0;
      first3_r   <= 1'b0;
      first4_r   <= 1'b0;
      last1_r    <= 1'b0;
      last2_r    <= 1'b0;
      last3_r    <= 1'b0;
      last4_r    <= 1'b0;
    end else begin
      v1_r       <= rd.en & rd.eval;
      first1_r   <= rd.first;
      last1_r    <= rd.last;
      v2_r       <= v1_r;
      first2_r   <= first1_r;
      last2_r    <= last1_r;
      v3_r       <= v2_r;
      first3_r   <= first2_r;
      last3_r    <= last2_r;
      v4_r       <= v3_r;
      first4_r   <= first3_r;
      last4_r    <= last3_r;
      cost_vld_r <= v4_r & last4_r;
    end
  end

  assign t_base   = first1_r ? '0 : t_r;
  assign due_ext  = wtes_pkg::TIME_W'(due2_r);
  assign sum_base = first4_r ? '0 : sum_r;
  assign sum_raw  = {1'b0, sum_base} + (wtes_pkg::COST_W + 1)'(prod_r);

  always_ff @(posedge clk) begin
    // Stage 1: running completion time.
    if (v1_r) begin
      t_r    <= t_base + wtes_pkg::TIME_W'(rd_data_r.ptime);
      due2_r <= rd_data_r.due;
      wt2_r  <= rd_data_r.wt;
    end
    // Stage 2: tardiness, zero when the job finishes on time.
    if (v2_r) begin
      tard_r <= (t_r > due_ext) ? (t_r - due_ext) : '0;
      wt3_r  <= wt2_r;
    end
    // Stage 3: weighted tardiness.
    if (v3_r) begin
      prod_r <= wtes_pkg::PROD_W'(tard_r * wt3_r);
    end
    // Stage 4: saturating accumulate.
    if (v4_r) begin
      sum_r <= sum_raw[wtes_pkg::COST_W] ? wtes_pkg::COST_MAX : sum_raw[wtes_pkg::COST_W-1:0];
    end
  end

  assign rd_data  = rd_data_r;
  assign cost_vld = cost_vld_r;
  assign cost     = sum_r;

endmodule

@@ hdl/wtes_search_seq.sv @@
// ----------------------------------------------------------------------------
// Weighted tardiness search sequencer
// Walks all job orders in recursive swap order with an explicit level stack,
// keeps the best order and hands it out one position at a time.
// ----------------------------------------------------------------------------
module wtes_search_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wtes_pkg::CNT_W-1:0]  start_n,
  input  logic                        out_full,
  input  logic                        cost_vld,
  input  logic [wtes_pkg::COST_W-1:0] cost,
  output logic                        busy,
  output wtes_pkg::rd_req_t           rd_req,
  output wtes_pkg::emit_t             emit
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_ENTER   = 7'b0000010,
    S_EVAL    = 7'b0000100,
    S_WAIT    = 7'b0001000,
    S_RET     = 7'b0010000,
    S_EMIT_RD = 7'b0100000,
    S_EMIT_LD = 7'b1000000
  } state_t;

  localparam int N  = wtes_pkg::MAX_TASKS;
  localparam int IW = wtes_pkg::IDX_W;
  localparam int CW = wtes_pkg::CNT_W;

  state_t state_r, state_nxt;

  logic [CW-1:0] lvl_r, lvl_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] idx_r [N];
  logic [CW-1:0] idx_nxt [N];
  logic [IW-1:0] perm_r [N];
  logic [IW-1:0] perm_nxt [N];
  logic [IW-1:0] best_r [N];
  logic [IW-1:0] best_nxt [N];
  logic [wtes_pkg::COST_W-1:0] min_cost_r, min_cost_nxt;

  logic [IW-1:0] perm_u [N];
  logic [IW-1:0] perm_s [N];
  logic [CW-1:0] p_lvl;
  logic [IW-1:0] pi;
  logic [CW-1:0] i_cur;
  logic [CW-1:0] j_nxt;
  logic          k_last;

  assign p_lvl  = lvl_r - CW'(1);
  assign pi     = p_lvl[IW-1:0];
  assign i_cur  = idx_r[pi];
  assign j_nxt  = i_cur + CW'(1);
  assign k_last = (k_r == n_r - CW'(1));

  // Undo the swap of this level, then apply the swap for its next choice.
  always_comb begin
    perm_u = perm_r;
    perm_u[pi] = perm_r[i_cur[IW-1:0]];
    perm_u[i_cur[IW-1:0]] = perm_r[pi];
    perm_s = perm_u;
    if (j_nxt < n_r) begin
      perm_s[pi] = perm_u[j_nxt[IW-1:0]];
      perm_s[j_nxt[IW-1:0]] = perm_u[pi];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    lvl_nxt      = lvl_r;
    n_nxt        = n_r;
    k_nxt        = k_r;
    idx_nxt      = idx_r;
    perm_nxt     = perm_r;
    best_nxt     = best_r;
    min_cost_nxt = min_cost_r;
    rd_req       = '0;
    emit         = '0;
    emit.cost    = min_cost_r;
    emit.last    = k_last;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          n_nxt        = start_n;
          lvl_nxt      = '0;
          min_cost_nxt = wtes_pkg::COST_MAX;
          for (int g = 0; g < N; g++) begin
            perm_nxt[g] = IW'(g);
          end
          state_nxt    = S_ENTER;
        end
      end
      S_ENTER: begin
        if (lvl_r == n_r) begin
          k_nxt     = '0;
          state_nxt = S_EVAL;
        end else begin
          idx_nxt[lvl_r[IW-1:0]] = lvl_r;
          lvl_nxt = lvl_r + CW'(1);
        end
      end
      S_EVAL: begin
        rd_req.en    = 1'b1;
        rd_req.eval  = 1'b1;
        rd_req.first = (k_r == '0);
        rd_req.last  = k_last;
        rd_req.addr  = perm_r[k_r[IW-1:0]];
        k_nxt        = k_r + CW'(1);
        if (k_last) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (cost_vld) begin
          if (min_cost_r >= cost) begin
            min_cost_nxt = cost;
            best_nxt     = perm_r;
          end
          state_nxt = S_RET;
        end
      end
      S_RET: begin
        if (lvl_r == '0) begin
          k_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          perm_nxt = perm_s;
          if (j_nxt < n_r) begin
            idx_nxt[pi] = j_nxt;
            state_nxt   = S_ENTER;
          end else begin
            lvl_nxt = p_lvl;
          end
        end
      end
      S_EMIT_RD: begin
        if (!out_full) begin
          rd_req.en   = 1'b1;
          rd_req.addr = best_r[k_r[IW-1:0]];
          state_nxt   = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        emit.vld = 1'b1;
        k_nxt    = k_r + CW'(1);
        state_nxt = k_last ? S_IDLE : S_EMIT_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lvl_r   <= '0;
      n_r     <= '0;
      k_r     <= '0;
      for (int g = 0; g < N; g++) begin
        idx_r[g] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
      n_r     <= n_nxt;
      k_r     <= k_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    perm_r     <= perm_nxt;
    best_r     <= best_nxt;
    min_cost_r <= min_cost_nxt;
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ hdl/weighted_tardiness_exhaustive_search_core.sv @@
// ----------------------------------------------------------------------------
// Weighted tardiness exhaustive search core
// Loads a batch of jobs and finds the order with the lowest total weighted
// tardiness by trying every order of the batch.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Moves
//   -------   ----------------------------   ----------------------------------
//   input     in_valid, in_stall, in_data    one job per transfer
//   output    out_valid, out_stall, out_data one position of best order each
//
// A job marked last starts the search over all n! orders of the n stored jobs.
// Each order is read through the shared cost pipeline, and every call of the
// recursion adds an entry and a return step. Results leave one at a time,
// each read only once the output register is empty. Reset clears the job count
// and the sequencer. in_stall stays high from the search start until the last
// result is loaded; out_stall holds the output and so the next result.
//
module weighted_tardiness_exhaustive_search_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wtes_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wtes_pkg::out_item_t out_data
);

  localparam int CW = wtes_pkg::CNT_W;

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  wtes_pkg::out_item_t out_data_r;

  logic                        in_xfer;
  logic                        has_room;
  logic [CW-1:0]               count_inc;
  logic                        start;
  logic                        busy;
  logic                        cost_vld;
  logic [wtes_pkg::COST_W-1:0] cost;
  wtes_pkg::mem_wr_t           wr;
  wtes_pkg::rd_req_t           rd_req;
  wtes_pkg::job_t              rd_data;
  wtes_pkg::emit_t             emit;

  // Jobs are only taken while the sequencer is idle.
  assign in_stall = busy;
  assign in_xfer  = in_valid & ~in_stall;

  // A full store drops further jobs, but the last mark still starts a search.
  assign has_room  = (count_r < CW'(wtes_pkg::MAX_TASKS));
  assign count_inc = count_r + (has_room ? CW'(1) : CW'(0));
  assign start     = in_xfer & in_data.last_job;

  always_comb begin
    wr          = '0;
    wr.en       = in_xfer & has_room;
    wr.addr     = count_r[wtes_pkg::IDX_W-1:0];
    wr.data.id    = in_data.job_id;
    wr.data.ptime = in_data.proc_time;
    wr.data.wt    = in_data.weight;
    wr.data.due   = in_data.due_date;
  end

  always_comb begin
    count_nxt = count_r;
    if (in_xfer) begin
      count_nxt = in_data.last_job ? '0 : count_inc;
    end
  end

  wtes_cost_unit u_cost (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .rd       (rd_req),
    .rd_data  (rd_data),
    .cost_vld (cost_vld),
    .cost     (cost)
  );

  wtes_search_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .start_n  (count_inc),
    .out_full (out_valid_r),
    .cost_vld (cost_vld),
    .cost     (cost),
    .busy     (busy),
    .rd_req   (rd_req),
    .emit     (emit)
  );

  // The output register is loaded only when it is empty, so a pending
  // transfer is never overwritten.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit.vld) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.vld) begin
      out_data_r.order_id    <= rd_data.id;
      out_data_r.best_cost   <= emit.cost;
      out_data_r.last_result <= emit.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
